### hw/rtl/odt_pkg.sv
// Shared types and constants for the ADC DC offset tracker.
// No dependencies; every other file in hw/rtl but odt_ram depends on this package.
package odt_pkg;

  // Number of tracked channels and the state memory address width
  localparam int CHANNELS = 2;
  localparam int CH_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Field widths
  localparam int SAMPLE_W = 16;
  localparam int COUNT_W  = 20;
  localparam int CFG_IW   = 3;
  localparam int CFG_DW   = 20;

  // Running average weight: avg' = (sample + (2^AVG_SHIFT - 1) * avg) >> AVG_SHIFT
  localparam int AVG_SHIFT = 7;
  localparam int SUM_W     = SAMPLE_W + AVG_SHIFT;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;
  localparam logic [COUNT_W-1:0]  COUNT_MAX  = '1;

  // Register reset values
  localparam logic [SAMPLE_W-1:0] WINDOW_LOW_RST    = 16'd33000;
  localparam logic [SAMPLE_W-1:0] WINDOW_HIGH_RST   = 16'd34500;
  localparam logic [COUNT_W-1:0]  SETTLE_COUNT_RST  = 20'd1000000;
  localparam logic [SAMPLE_W-1:0] START_AVERAGE_RST = 16'd33791;
  localparam logic [SAMPLE_W-1:0] START_ZERO_RST    = 16'd33791;

  // Register indexes
  typedef enum logic [CFG_IW-1:0] {
    REG_WINDOW_LOW    = 3'd0,
    REG_WINDOW_HIGH   = 3'd1,
    REG_SETTLE_COUNT  = 3'd2,
    REG_START_AVERAGE = 3'd3,
    REG_START_ZERO    = 3'd4
  } cfg_reg_e;

  // Configuration register contents
  typedef struct packed {
    logic [SAMPLE_W-1:0] window_low;
    logic [SAMPLE_W-1:0] window_high;
    logic [COUNT_W-1:0]  settle_count;
    logic [SAMPLE_W-1:0] start_average;
    logic [SAMPLE_W-1:0] start_zero;
  } cfg_t;

  // Reload strobes towards the per-channel state
  typedef struct packed {
    logic avg;
    logic zero;
  } load_t;

  // One channel's state as stored in memory
  typedef struct packed {
    logic [SAMPLE_W-1:0] avg;
    logic [COUNT_W-1:0]  cnt;
    logic [SAMPLE_W-1:0] off;
  } entry_t;

endpackage

### hw/rtl/odt_stream_if.sv
// Stream interfaces for sample beats in and result beats out.
// Depends on odt_pkg for field widths.
interface odt_in_if;
  logic                            valid;
  logic                            ready;
  logic [odt_pkg::SAMPLE_W-1:0]    sample;
  logic                            chan;

  modport source (output valid, output sample, output chan, input ready);
  modport sink   (input valid, input sample, input chan, output ready);
endinterface

interface odt_out_if;
  logic                            valid;
  logic                            ready;
  logic                            out_chan;
  logic [odt_pkg::SAMPLE_W-1:0]    zero_offset;
  logic [odt_pkg::SAMPLE_W-1:0]    running_average;
  logic                            stepped;

  modport source (output valid, output out_chan, output zero_offset,
                  output running_average, output stepped, input ready);
  modport sink   (input valid, input out_chan, input zero_offset,
                  input running_average, input stepped, output ready);
endinterface

### hw/rtl/adc_dc_offset_tracker_unit.sv
// ADC DC offset tracker: per-channel running average, quiet counter and zero offset.
// An accepted sample beat passes through stage 1 (memory read) and the output register.
// Throughput: one sample per cycle while the result side takes beats, with a read-modify-write
// of the channel state memory and the last write forwarded to a same-channel read.
// Reset: registers take their reset values and every channel entry is marked stale,
// so it reads as start_average / 0 / start_zero until first written; no clearing pass.
module adc_dc_offset_tracker_unit (
  input  logic                         clk,
  input  logic                         rst,
  odt_in_if.sink                       samples,
  odt_out_if.source                    results,
  input  logic                         cfg_we,
  input  logic [odt_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [odt_pkg::CFG_DW-1:0]   cfg_data
);
  import odt_pkg::*;

  localparam int ENTRY_W = $bits(entry_t);

  cfg_t  cfg;
  load_t load;

  // Stage 1: memory read in flight
  logic                s1_valid;
  logic [SAMPLE_W-1:0] s1_sample;
  logic                s1_chan;
  logic                s1_adv;
  logic                s1_chan_ok;
  logic [CH_AW-1:0]    s1_addr;

  // Output register
  logic                out_valid;
  logic                out_chan;
  logic [SAMPLE_W-1:0] out_offset;
  logic [SAMPLE_W-1:0] out_average;
  logic                out_stepped;

  // Memory ports and forwarding
  logic                rd_en;
  logic [CH_AW-1:0]    rd_addr;
  logic [ENTRY_W-1:0]  rd_data;
  entry_t              ram_entry;
  logic                wr_en;
  entry_t              wr_entry;
  logic                fwd_hit;
  entry_t              fwd_entry;

  // Per-channel fresh marks: a stale field reads as its start value
  logic [CHANNELS-1:0] avg_ok;
  logic [CHANNELS-1:0] cnt_ok;
  logic [CHANNELS-1:0] off_ok;

  entry_t              cur;
  entry_t              upd;
  logic                step;

  odt_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .load      (load)
  );

  // Handshake: stage 1 drains into the output register when it is free
  assign s1_adv        = s1_valid && (!out_valid || results.ready);
  assign samples.ready = !s1_valid || s1_adv;
  assign rd_en         = samples.valid && samples.ready;
  assign rd_addr       = CH_AW'(samples.chan);
  assign s1_addr       = CH_AW'(s1_chan);
  assign s1_chan_ok    = (int'(s1_chan) < CHANNELS);

  odt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CHANNELS)
  ) u_state_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_addr),
    .wdata (wr_entry),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign ram_entry = entry_t'(rd_data);

  // Advance stage 1 and capture a write that collides with the read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else begin
      if (rd_en) begin
        s1_valid <= 1'b1;
        fwd_hit  <= wr_en && (s1_addr == rd_addr);
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_sample <= samples.sample;
      s1_chan   <= samples.chan;
      fwd_entry <= wr_entry;
    end
  end

  // Select current state: forwarded write, memory, or start values
  always_comb begin
    if (fwd_hit) begin
      cur = fwd_entry;
    end else begin
      cur.avg = avg_ok[s1_addr] ? ram_entry.avg : cfg.start_average;
      cur.cnt = cnt_ok[s1_addr] ? ram_entry.cnt : '0;
      cur.off = off_ok[s1_addr] ? ram_entry.off : cfg.start_zero;
    end
  end

  odt_update u_update (
    .sample  (s1_sample),
    .cfg     (cfg),
    .cur     (cur),
    .upd     (upd),
    .stepped (step)
  );

  assign wr_en    = s1_adv && s1_chan_ok;
  assign wr_entry = upd;

  // Mark entries fresh on write back; reload strobes make the average or offset marks stale again
  always_ff @(posedge clk) begin
    if (rst) begin
      avg_ok <= '0;
      cnt_ok <= '0;
      off_ok <= '0;
    end else begin
      if (wr_en) begin
        avg_ok[s1_addr] <= 1'b1;
        cnt_ok[s1_addr] <= 1'b1;
        off_ok[s1_addr] <= 1'b1;
      end
      if (load.avg) begin
        avg_ok <= '0;
      end
      if (load.zero) begin
        off_ok <= '0;
      end
    end
  end

  // Output register: hold until the result beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_chan    <= s1_chan;
      out_offset  <= s1_chan_ok ? upd.off : '0;
      out_average <= s1_chan_ok ? upd.avg : '0;
      out_stepped <= s1_chan_ok && step;
    end
  end

  assign results.valid           = out_valid;
  assign results.out_chan        = out_chan;
  assign results.zero_offset     = out_offset;
  assign results.running_average = out_average;
  assign results.stepped         = out_stepped;

endmodule

### hw/rtl/odt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module odt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, old data on a same-address collision
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/odt_cfg_regs.sv
// Configuration registers of the DC offset tracker and reload strobes.
// Depends on odt_pkg.
module odt_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [odt_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [odt_pkg::CFG_DW-1:0]   cfg_data,
  output odt_pkg::cfg_t                cfg,
  output odt_pkg::load_t               load
);
  import odt_pkg::*;

  cfg_t  regs;
  load_t strobe;

  // Decode the write; unknown indexes are dropped
  always_comb begin
    strobe = '0;
    if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_START_AVERAGE: strobe.avg  = 1'b1;
        REG_START_ZERO:    strobe.zero = 1'b1;
        default:           strobe      = '0;
      endcase
    end
  end

  // Hold register values
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.window_low    <= WINDOW_LOW_RST;
      regs.window_high   <= WINDOW_HIGH_RST;
      regs.settle_count  <= SETTLE_COUNT_RST;
      regs.start_average <= START_AVERAGE_RST;
      regs.start_zero    <= START_ZERO_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_WINDOW_LOW:    regs.window_low    <= cfg_data[SAMPLE_W-1:0];
        REG_WINDOW_HIGH:   regs.window_high   <= cfg_data[SAMPLE_W-1:0];
        REG_SETTLE_COUNT:  regs.settle_count  <= cfg_data[COUNT_W-1:0];
        REG_START_AVERAGE: regs.start_average <= cfg_data[SAMPLE_W-1:0];
        REG_START_ZERO:    regs.start_zero    <= cfg_data[SAMPLE_W-1:0];
        default:           regs               <= regs;
      endcase
    end
  end

  assign cfg  = regs;
  assign load = strobe;

endmodule

### hw/rtl/odt_update.sv
// Per-sample update of one channel's average, quiet counter and offset.
// Depends on odt_pkg.
module odt_update (
  input  logic [odt_pkg::SAMPLE_W-1:0] sample,
  input  odt_pkg::cfg_t                cfg,
  input  odt_pkg::entry_t              cur,
  output odt_pkg::entry_t              upd,
  output logic                         stepped
);
  import odt_pkg::*;

  logic               in_window;
  logic [SUM_W-1:0]   sum;
  logic [SAMPLE_W-1:0] new_avg;
  logic               settled;
  logic [SAMPLE_W-1:0] off_moved;

  // Silence window test, both bounds exclusive
  assign in_window = (sample > cfg.window_low) && (sample < cfg.window_high);

  // sample + 127*avg, written as (avg << 7) - avg
  assign sum     = {{AVG_SHIFT{1'b0}}, sample}
                 + ({cur.avg, {AVG_SHIFT{1'b0}}} - {{AVG_SHIFT{1'b0}}, cur.avg});
  assign new_avg = sum[SUM_W-1:AVG_SHIFT];

  assign settled = (cur.cnt == cfg.settle_count);

  // Step towards the new average, saturating at the top code
  always_comb begin
    priority if (cur.off > new_avg) begin
      off_moved = cur.off - 1'b1;
    end else if (cur.off != SAMPLE_MAX) begin
      off_moved = cur.off + 1'b1;
    end else begin
      off_moved = cur.off;
    end
  end

  // Assemble the updated entry
  always_comb begin
    upd     = cur;
    stepped = 1'b0;
    if (in_window) begin
      upd.avg = new_avg;
      priority if (settled) begin
        upd.off = off_moved;
        upd.cnt = COUNT_W'(1);
        stepped = 1'b1;
      end else if (cur.cnt != COUNT_MAX) begin
        upd.cnt = cur.cnt + 1'b1;
      end else begin
        // hold the counter at its top value
        upd.cnt = cur.cnt;
      end
    end else begin
      upd.cnt = '0;
    end
  end

endmodule

### sim/tb_adc_dc_offset_tracker_unit.sv
// Testbench for adc_dc_offset_tracker_unit: drives sample beats and register writes,
// predicts every result beat per channel and checks it field by field.
// Depends on odt_pkg and the odt_in_if / odt_out_if stream interfaces.
module tb_adc_dc_offset_tracker_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import odt_pkg::*;

  localparam int RESULT_LATENCY = 2;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 68;
  localparam int IDLE_PERCENT   = 34;
  localparam int HOLD_CYCLES    = 120;
  localparam logic [CFG_IW-1:0] REG_UNUSED = 3'd7;

  // Per-channel offset tracker prediction and the queue of results still due
  class offset_tracker_sb;
    typedef struct {
      logic                out_chan;
      logic [SAMPLE_W-1:0] zero_offset;
      logic [SAMPLE_W-1:0] running_average;
      logic                stepped;
    } tracker_result_t;

    logic [SAMPLE_W-1:0] win_lo;
    logic [SAMPLE_W-1:0] win_hi;
    logic [COUNT_W-1:0]  settle;
    logic [SAMPLE_W-1:0] start_avg;
    logic [SAMPLE_W-1:0] start_zero;
    logic [SAMPLE_W-1:0] avg_of    [CHANNELS];
    logic [COUNT_W-1:0]  quiet_of  [CHANNELS];
    logic [SAMPLE_W-1:0] offset_of [CHANNELS];
    tracker_result_t     due_results [$];
    int unsigned         errors;

    function new();
      win_lo     = WINDOW_LOW_RST;
      win_hi     = WINDOW_HIGH_RST;
      settle     = SETTLE_COUNT_RST;
      start_avg  = START_AVERAGE_RST;
      start_zero = START_ZERO_RST;
      foreach (avg_of[c]) begin
        avg_of[c]    = START_AVERAGE_RST;
        quiet_of[c]  = '0;
        offset_of[c] = START_ZERO_RST;
      end
      errors = 0;
    endfunction

    // Loading a start value overwrites that field in every channel
    function void write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
      case (idx)
        REG_WINDOW_LOW:   win_lo = data[SAMPLE_W-1:0];
        REG_WINDOW_HIGH:  win_hi = data[SAMPLE_W-1:0];
        REG_SETTLE_COUNT: settle = data[COUNT_W-1:0];
        REG_START_AVERAGE: begin
          start_avg = data[SAMPLE_W-1:0];
          foreach (avg_of[c]) avg_of[c] = start_avg;
        end
        REG_START_ZERO: begin
          start_zero = data[SAMPLE_W-1:0];
          foreach (offset_of[c]) offset_of[c] = start_zero;
        end
        default: ;
      endcase
    endfunction

    // Advance the channel state for one accepted sample beat
    function void note_sample(logic [SAMPLE_W-1:0] smp, logic ch);
      tracker_result_t  r;
      logic [SUM_W-1:0] sum;
      r.out_chan = ch;
      r.stepped  = 1'b0;
      if (smp > win_lo && smp < win_hi) begin
        sum = SUM_W'(smp) + SUM_W'(avg_of[ch]) * SUM_W'((1 << AVG_SHIFT) - 1);
        avg_of[ch] = sum[SUM_W-1:AVG_SHIFT];
        if (quiet_of[ch] == settle) begin
          // step towards the average; equal counts as below
          if (offset_of[ch] > avg_of[ch]) offset_of[ch] = offset_of[ch] - 1'b1;
          else if (offset_of[ch] != SAMPLE_MAX) offset_of[ch] = offset_of[ch] + 1'b1;
          r.stepped    = 1'b1;
          quiet_of[ch] = COUNT_W'(1);
        end else if (quiet_of[ch] != COUNT_MAX) begin
          quiet_of[ch] = quiet_of[ch] + 1'b1;
        end
      end else begin
        quiet_of[ch] = '0;
      end
      r.zero_offset     = offset_of[ch];
      r.running_average = avg_of[ch];
      due_results.push_back(r);
    endfunction

    function void match_field(string name, logic [SAMPLE_W-1:0] want,
                              logic [SAMPLE_W-1:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    // Compare one result beat against the oldest prediction
    function void check_result(logic ch, logic [SAMPLE_W-1:0] off,
                               logic [SAMPLE_W-1:0] avg, logic st);
      tracker_result_t r;
      if (due_results.size() == 0) begin
        $error("result beat on channel %0d with no sample outstanding", ch);
        errors++;
      end else begin
        r = due_results.pop_front();
        match_field("out_chan", SAMPLE_W'(r.out_chan), SAMPLE_W'(ch));
        match_field("zero_offset", r.zero_offset, off);
        match_field("running_average", r.running_average, avg);
        match_field("stepped", SAMPLE_W'(r.stepped), SAMPLE_W'(st));
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                cfg_we;
  logic [CFG_IW-1:0]   cfg_index;
  logic [CFG_DW-1:0]   cfg_data;
  int unsigned         sent_items = 0;
  offset_tracker_sb    sb = new();

  odt_in_if  samples_if ();
  odt_out_if results_if ();

  adc_dc_offset_tracker_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples_if),
    .results   (results_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Offer one sample beat, idling at random outside the no-gap stretch
  task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic ch);
    while (!(sent_items >= 150 && sent_items < 250) &&
           $urandom_range(99) < IDLE_PERCENT) begin
      samples_if.valid <= 1'b0;
      @(posedge clk);
    end
    samples_if.valid  <= 1'b1;
    samples_if.sample <= smp;
    samples_if.chan   <= ch;
    @(posedge clk);
    while (!samples_if.ready) @(posedge clk);
    sb.note_sample(smp, ch);
    sent_items++;
  endtask

  // Stop offering and wait until every due result has come back
  task automatic drain_results();
    samples_if.valid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // Reprogram the registers once the block has gone idle
  task automatic configure(input int unsigned lo, hi, st, avg0, zero0,
                           input bit load_avg, load_zero);
    drain_results();
    write_reg(REG_WINDOW_LOW, CFG_DW'(lo));
    write_reg(REG_WINDOW_HIGH, CFG_DW'(hi));
    write_reg(REG_SETTLE_COUNT, CFG_DW'(st));
    if (load_avg) write_reg(REG_START_AVERAGE, CFG_DW'(avg0));
    if (load_zero) write_reg(REG_START_ZERO, CFG_DW'(zero0));
    // an unused index must leave every register alone
    write_reg(REG_UNUSED, CFG_DW'($urandom));
    cfg_we <= 1'b0;
  endtask

  // Result side: check each beat, stall at random outside an always-ready stretch, hold off twice for a long stretch
  initial begin : result_sink
    int unsigned beats_seen;
    int unsigned hold_left;
    beats_seen = 0;
    hold_left  = 0;
    results_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (results_if.valid && results_if.ready) begin
        sb.check_result(results_if.out_chan, results_if.zero_offset,
                        results_if.running_average, results_if.stepped);
        beats_seen++;
        if (beats_seen == 80 || beats_seen == 450) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        results_if.ready <= 1'b0;
      end else if (beats_seen >= 250 && beats_seen < 400) begin
        results_if.ready <= 1'b1;
      end else begin
        results_if.ready <= ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  initial begin : stimulus
    int unsigned lo, hi, mid, half, st, avg0, zero0, pick;
    bit          load_avg, load_zero;
    logic [SAMPLE_W-1:0] smp;
    samples_if.valid  <= 1'b0;
    samples_if.sample <= '0;
    samples_if.chan   <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: sample extremes and both window edges
    send_sample(16'd0, 1'b0);
    send_sample(16'hFFFF, 1'b1);
    send_sample(16'd33001, 1'b0);
    send_sample(16'd33000, 1'b0);
    send_sample(16'd34500, 1'b1);
    send_sample(16'd34499, 1'b1);

    // Settle count zero: step on the first quiet sample after a clear
    configure(0, 65535, 0, 40000, 30000, 1'b1, 1'b1);
    send_sample(16'd1, 1'b0);
    send_sample(16'd20000, 1'b0);
    send_sample(16'd0, 1'b0);
    send_sample(16'd65534, 1'b0);
    send_sample(16'hFFFF, 1'b1);
    send_sample(16'd50000, 1'b1);

    // Offset at the top: step down, then up from equal
    configure(65000, 65535, 1, 65535, 65535, 1'b1, 1'b1);
    send_sample(16'd65534, 1'b1);
    send_sample(16'd65534, 1'b1);
    send_sample(16'd65534, 1'b1);
    send_sample(16'd65534, 1'b0);

    // Offset equal to the average steps up
    configure(0, 2000, 1, 1000, 1000, 1'b1, 1'b1);
    send_sample(16'd1000, 1'b0);
    send_sample(16'd1000, 1'b0);
    send_sample(16'd1000, 1'b0);

    // Random phases: mostly quiet samples around a random window
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      mid       = $urandom_range(2000, 63535);
      half      = $urandom_range(8, 1500);
      lo        = mid - half;
      hi        = mid + half;
      st        = $urandom_range(1, 6);
      avg0      = mid + $urandom_range(600) - 300;
      zero0     = mid + $urandom_range(600) - 300;
      load_avg  = 1'($urandom_range(1));
      load_zero = 1'($urandom_range(1));
      case (p)
        0: begin
          lo = 0;
          hi = 65535;
          st = 0;
          load_avg  = 1'b1;
          load_zero = 1'b1;
        end
        1: begin
          // inverted window: nothing is quiet
          lo = 65535;
          hi = 0;
        end
        2: begin
          st = 32'(COUNT_MAX);
          avg0 = 0;
          zero0 = 65535;
          load_avg  = 1'b1;
          load_zero = 1'b1;
        end
        3: begin
          avg0 = 65535;
          zero0 = 0;
          load_avg  = 1'b1;
          load_zero = 1'b1;
        end
        7: st = $urandom_range(10, 40);
        default: ;
      endcase
      configure(lo, hi, st, avg0, zero0, load_avg, load_zero);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        pick = $urandom_range(99);
        if (pick < 70 && sb.win_hi > sb.win_lo + 1)
          smp = SAMPLE_W'($urandom_range(sb.win_lo + 1, sb.win_hi - 1));
        else if (pick < 80)
          smp = pick[0] ? sb.win_lo : sb.win_hi;
        else
          smp = SAMPLE_W'($urandom);
        send_sample(smp, 1'($urandom_range(1)));
      end
    end

    drain_results();
    if (sb.errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  // Hard stop if the block hangs
  initial begin : run_limit
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
